@@ design/sbpp_pkg.sv @@
// Shared constants, types and reset tables for the spectral band peak picker.
package sbpp_pkg;

  localparam int FFT_BINS_DEF = 1024;
  localparam int BANDS_DEF    = 3;

  localparam int COMP_W      = 31;   // width of one real or imaginary part
  localparam int PWR_W       = 62;   // squared magnitude
  localparam int RANGE_W     = 11;   // range bound registers
  localparam int FRAME_W     = 24;   // frame counter
  localparam int IN_DATA_W   = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_IDX_LSB = 3;    // registers sit on 8-byte steps
  localparam int REG_BANDS   = 3;    // bands that own range registers

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_RANGE_LAST = 3'd5;
  localparam reg_idx_t REG_POWER_MIN  = 3'd6;

  // control that travels with every sample through the pipe
  typedef struct packed {
    logic vld;
    logic last;
  } tok_ctl_t;

  function automatic logic [RANGE_W-1:0] reset_low(input int band);
    logic [RANGE_W-1:0] val;
    case (band)
      0:       val = RANGE_W'(200);
      1:       val = RANGE_W'(300);
      2:       val = RANGE_W'(500);
      default: val = '0;
    endcase
    return val;
  endfunction

  function automatic logic [RANGE_W-1:0] reset_high(input int band);
    logic [RANGE_W-1:0] val;
    case (band)
      0:       val = RANGE_W'(300);
      1:       val = RANGE_W'(500);
      2:       val = RANGE_W'(800);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ design/spectral_band_peak_picker.sv @@
// Spectral band peak picker: per-band peak search over streamed FFT bins.
// Input stream takes one FFT bin per transaction: in_tdata carries the real and
// imaginary parts, in_tlast marks the last bin of a frame. Bins are numbered
// from 0 in arrival order. Each band cell keeps the strictly largest squared
// magnitude inside its [low, high) bin range. After a frame's last bin the
// band peaks at or above the power threshold leave on the output stream in
// band order, out_tlast on the frame's final one; a frame with none sends
// nothing but still advances the frame number.
// Throughput: one bin per cycle. A frame's last bin passes the power stages
// and the band cell registers and then loads the output buffer, which offers
// its first peak, then one peak per cycle. The buffer holds one frame; a
// further frame end waits at the tail of the cell chain until that buffer
// drains, and the whole pipe holds, in_tready low, meanwhile. Frames of at
// least BANDS + 1 bins never stall while the output is taken at once.
// A stalled receiver holds its peak and stops the pipe only as above.
// Reset (rst_n low, synchronous) clears counters, trackers and the output buffer and
// loads the default band ranges; the user writes the APB port only idle, unenforced.
module spectral_band_peak_picker #(
  parameter int FFT_BINS = sbpp_pkg::FFT_BINS_DEF,
  parameter int BANDS    = sbpp_pkg::BANDS_DEF,
  localparam int BIN_W   = $clog2(FFT_BINS),
  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1,
  localparam int DATA_W  = ((BIN_W + sbpp_pkg::PWR_W + sbpp_pkg::FRAME_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sbpp_pkg::IN_DATA_W-1:0]    in_tdata,   // bin_real[30:0], bin_imag[61:31], zero
  input  logic                              in_tlast,   // frame_end
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [DATA_W-1:0]                 out_tdata,  // peak_bin, peak_power, frame_number
  output logic [BAND_W-1:0]                 out_tuser,  // band
  output logic                              out_tlast,  // frame_last
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbpp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sbpp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sbpp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [BANDS-1:0][sbpp_pkg::RANGE_W-1:0]        range_low;
  logic [BANDS-1:0][sbpp_pkg::RANGE_W-1:0]        range_high;
  logic [sbpp_pkg::PWR_W-1:0]                     power_min;
  logic                                           adv;
  logic                                           busy;
  logic                                           in_take;

  sbpp_pkg::tok_ctl_t                             chain_ctl [BANDS+1];
  logic [BIN_W-1:0]                               chain_bin [BANDS+1];
  logic [sbpp_pkg::PWR_W-1:0]                     chain_pwr [BANDS+1];
  logic [BANDS-1:0][sbpp_pkg::PWR_W-1:0]          chain_res_pwr [BANDS+1];
  logic [BANDS-1:0][BIN_W-1:0]                    chain_res_bin [BANDS+1];

  // stall only when a frame end reaches the tail and the buffer is full
  assign adv       = !(chain_ctl[BANDS].vld && chain_ctl[BANDS].last && busy);
  assign in_tready = adv;
  assign in_take   = in_tvalid && adv;
  assign pready    = 1'b1;

  sbpp_regs #(
    .BANDS(BANDS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .range_low (range_low),
    .range_high(range_high),
    .power_min (power_min)
  );

  sbpp_power #(
    .FFT_BINS(FFT_BINS)
  ) u_power (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_take),
    .in_last(in_tlast),
    .in_real(in_tdata[sbpp_pkg::COMP_W-1:0]),
    .in_imag(in_tdata[2*sbpp_pkg::COMP_W-1:sbpp_pkg::COMP_W]),
    .out_ctl(chain_ctl[0]),
    .out_bin(chain_bin[0]),
    .out_pwr(chain_pwr[0])
  );

  assign chain_res_pwr[0] = '0;
  assign chain_res_bin[0] = '0;

  for (genvar g = 0; g < BANDS; g++) begin : g_cell
    sbpp_cell #(
      .FFT_BINS(FFT_BINS),
      .BANDS   (BANDS),
      .IDX     (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .range_low  (range_low[g]),
      .range_high (range_high[g]),
      .in_ctl     (chain_ctl[g]),
      .in_bin     (chain_bin[g]),
      .in_pwr     (chain_pwr[g]),
      .in_res_pwr (chain_res_pwr[g]),
      .in_res_bin (chain_res_bin[g]),
      .out_ctl    (chain_ctl[g+1]),
      .out_bin    (chain_bin[g+1]),
      .out_pwr    (chain_pwr[g+1]),
      .out_res_pwr(chain_res_pwr[g+1]),
      .out_res_bin(chain_res_bin[g+1])
    );
  end

  sbpp_emit #(
    .FFT_BINS(FFT_BINS),
    .BANDS   (BANDS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail_ctl  (chain_ctl[BANDS]),
    .res_pwr   (chain_res_pwr[BANDS]),
    .res_bin   (chain_res_bin[BANDS]),
    .power_min (power_min),
    .busy      (busy),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

@@ design/sbpp_regs.sv @@
// Configuration register file: band ranges and power threshold.
module sbpp_regs #(
  parameter int BANDS = sbpp_pkg::BANDS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [sbpp_pkg::CFG_ADDR_W-1:0]             paddr,
  input  logic [sbpp_pkg::CFG_DATA_W-1:0]             pwdata,
  output logic [sbpp_pkg::CFG_DATA_W-1:0]             prdata,
  output logic [BANDS-1:0][sbpp_pkg::RANGE_W-1:0]     range_low,
  output logic [BANDS-1:0][sbpp_pkg::RANGE_W-1:0]     range_high,
  output logic [sbpp_pkg::PWR_W-1:0]                  power_min
);

  logic [BANDS-1:0][sbpp_pkg::RANGE_W-1:0] low_r;
  logic [BANDS-1:0][sbpp_pkg::RANGE_W-1:0] high_r;
  logic [sbpp_pkg::PWR_W-1:0]              power_min_r;
  sbpp_pkg::reg_idx_t                      reg_idx;
  logic                                    wr_en;

  assign reg_idx = paddr[sbpp_pkg::CFG_ADDR_W-1:sbpp_pkg::CFG_IDX_LSB];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BANDS; b++) begin
        low_r[b]  <= sbpp_pkg::reset_low(b);
        high_r[b] <= sbpp_pkg::reset_high(b);
      end
      power_min_r <= '0;
    end else if (wr_en) begin
      if (reg_idx == sbpp_pkg::REG_POWER_MIN) begin
        power_min_r <= pwdata[sbpp_pkg::PWR_W-1:0];
      end
      // range registers come in low/high pairs, one pair per band
      for (int b = 0; b < BANDS; b++) begin
        if (reg_idx <= sbpp_pkg::REG_RANGE_LAST && 32'(reg_idx[2:1]) == b) begin
          if (reg_idx[0]) begin
            high_r[b] <= pwdata[sbpp_pkg::RANGE_W-1:0];
          end else begin
            low_r[b] <= pwdata[sbpp_pkg::RANGE_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == sbpp_pkg::REG_POWER_MIN) begin
      prdata = sbpp_pkg::CFG_DATA_W'(power_min_r);
    end
    for (int b = 0; b < BANDS; b++) begin
      if (reg_idx <= sbpp_pkg::REG_RANGE_LAST && 32'(reg_idx[2:1]) == b) begin
        prdata = sbpp_pkg::CFG_DATA_W'(reg_idx[0] ? high_r[b] : low_r[b]);
      end
    end
  end

  assign range_low  = low_r;
  assign range_high = high_r;
  assign power_min  = power_min_r;

endmodule

@@ design/sbpp_power.sv @@
// Bin counter and three-stage squared-magnitude pipeline.
module sbpp_power #(
  parameter int FFT_BINS = sbpp_pkg::FFT_BINS_DEF,
  localparam int BIN_W   = $clog2(FFT_BINS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic                              in_last,
  input  logic [sbpp_pkg::COMP_W-1:0]       in_real,
  input  logic [sbpp_pkg::COMP_W-1:0]       in_imag,
  output sbpp_pkg::tok_ctl_t                out_ctl,
  output logic [BIN_W-1:0]                  out_bin,
  output logic [sbpp_pkg::PWR_W-1:0]        out_pwr
);

  logic [BIN_W-1:0]               bin_cnt_r;
  logic [BIN_W-1:0]               bin_cnt_nxt;

  sbpp_pkg::tok_ctl_t             s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [BIN_W-1:0]               s1_bin_r, s2_bin_r, s3_bin_r;
  logic [sbpp_pkg::COMP_W-1:0]    abs_re, abs_im;
  logic [sbpp_pkg::COMP_W-1:0]    abs_re_r, abs_im_r;
  logic [sbpp_pkg::PWR_W-1:0]     prod_re, prod_im;
  logic [sbpp_pkg::PWR_W-1:0]     sq_re_r, sq_im_r;
  logic [sbpp_pkg::PWR_W-1:0]     pwr_r;

  // most negative input maps onto 2^30, which still fits unsigned
  assign abs_re = in_real[sbpp_pkg::COMP_W-1] ? (~in_real + 1'b1) : in_real;
  assign abs_im = in_imag[sbpp_pkg::COMP_W-1] ? (~in_imag + 1'b1) : in_imag;

  assign prod_re = sbpp_pkg::PWR_W'(abs_re_r) * sbpp_pkg::PWR_W'(abs_re_r);
  assign prod_im = sbpp_pkg::PWR_W'(abs_im_r) * sbpp_pkg::PWR_W'(abs_im_r);

  always_comb begin
    bin_cnt_nxt = bin_cnt_r;
    if (in_vld) begin
      if (in_last || bin_cnt_r == BIN_W'(FFT_BINS - 1)) begin
        bin_cnt_nxt = '0;
      end else begin
        bin_cnt_nxt = bin_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      s1_ctl_r  <= '0;
      s2_ctl_r  <= '0;
      s3_ctl_r  <= '0;
    end else if (adv) begin
      bin_cnt_r <= bin_cnt_nxt;
      s1_ctl_r  <= '{vld: in_vld, last: in_last};
      s2_ctl_r  <= s1_ctl_r;
      s3_ctl_r  <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abs_re_r <= abs_re;
      abs_im_r <= abs_im;
      s1_bin_r <= bin_cnt_r;
      sq_re_r  <= prod_re;
      sq_im_r  <= prod_im;
      s2_bin_r <= s1_bin_r;
      pwr_r    <= sq_re_r + sq_im_r;   // at most 2^61, no carry out
      s3_bin_r <= s2_bin_r;
    end
  end

  assign out_ctl = s3_ctl_r;
  assign out_bin = s3_bin_r;
  assign out_pwr = pwr_r;

endmodule

@@ design/sbpp_cell.sv @@
// One band tracker cell: keeps the band peak, passes samples and results on.
module sbpp_cell #(
  parameter int FFT_BINS = sbpp_pkg::FFT_BINS_DEF,
  parameter int BANDS    = sbpp_pkg::BANDS_DEF,
  parameter int IDX      = 0,
  localparam int BIN_W   = $clog2(FFT_BINS)
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    adv,
  input  logic [sbpp_pkg::RANGE_W-1:0]            range_low,
  input  logic [sbpp_pkg::RANGE_W-1:0]            range_high,
  input  sbpp_pkg::tok_ctl_t                      in_ctl,
  input  logic [BIN_W-1:0]                        in_bin,
  input  logic [sbpp_pkg::PWR_W-1:0]              in_pwr,
  input  logic [BANDS-1:0][sbpp_pkg::PWR_W-1:0]   in_res_pwr,
  input  logic [BANDS-1:0][BIN_W-1:0]             in_res_bin,
  output sbpp_pkg::tok_ctl_t                      out_ctl,
  output logic [BIN_W-1:0]                        out_bin,
  output logic [sbpp_pkg::PWR_W-1:0]              out_pwr,
  output logic [BANDS-1:0][sbpp_pkg::PWR_W-1:0]   out_res_pwr,
  output logic [BANDS-1:0][BIN_W-1:0]             out_res_bin
);

  localparam int CMP_W = (BIN_W > sbpp_pkg::RANGE_W) ? BIN_W : sbpp_pkg::RANGE_W;

  logic [sbpp_pkg::PWR_W-1:0]              best_pwr_r;
  logic [BIN_W-1:0]                        best_bin_r;
  sbpp_pkg::tok_ctl_t                      ctl_r;
  logic [BIN_W-1:0]                        bin_r;
  logic [sbpp_pkg::PWR_W-1:0]              pwr_r;
  logic [BANDS-1:0][sbpp_pkg::PWR_W-1:0]   res_pwr_r;
  logic [BANDS-1:0][BIN_W-1:0]             res_bin_r;
  logic [BANDS-1:0][sbpp_pkg::PWR_W-1:0]   res_pwr_nxt;
  logic [BANDS-1:0][BIN_W-1:0]             res_bin_nxt;
  logic                                    in_band;
  logic                                    hit;
  logic                                    frame_done;
  logic [sbpp_pkg::PWR_W-1:0]              cand_pwr;
  logic [BIN_W-1:0]                        cand_bin;

  assign in_band = CMP_W'(in_bin) >= CMP_W'(range_low) &&
                   CMP_W'(in_bin) <  CMP_W'(range_high);
  // strict compare: the earliest bin keeps a tie
  assign hit        = in_ctl.vld && in_band && (in_pwr > best_pwr_r);
  assign frame_done = in_ctl.vld && in_ctl.last;
  assign cand_pwr   = hit ? in_pwr : best_pwr_r;
  assign cand_bin   = hit ? in_bin : best_bin_r;

  always_comb begin
    res_pwr_nxt = in_res_pwr;
    res_bin_nxt = in_res_bin;
    if (frame_done) begin
      res_pwr_nxt[IDX] = cand_pwr;
      res_bin_nxt[IDX] = cand_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_pwr_r <= '0;
      best_bin_r <= '0;
      ctl_r      <= '0;
    end else if (adv) begin
      ctl_r <= in_ctl;
      if (frame_done) begin
        best_pwr_r <= '0;
        best_bin_r <= '0;
      end else if (hit) begin
        best_pwr_r <= in_pwr;
        best_bin_r <= in_bin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bin_r     <= in_bin;
      pwr_r     <= in_pwr;
      res_pwr_r <= res_pwr_nxt;
      res_bin_r <= res_bin_nxt;
    end
  end

  assign out_ctl     = ctl_r;
  assign out_bin     = bin_r;
  assign out_pwr     = pwr_r;
  assign out_res_pwr = res_pwr_r;
  assign out_res_bin = res_bin_r;

endmodule

@@ design/sbpp_emit.sv @@
// Result buffer: thresholds one frame's band peaks and sends them in band order.
module sbpp_emit #(
  parameter int FFT_BINS = sbpp_pkg::FFT_BINS_DEF,
  parameter int BANDS    = sbpp_pkg::BANDS_DEF,
  localparam int BIN_W   = $clog2(FFT_BINS),
  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1,
  localparam int DATA_W  = ((BIN_W + sbpp_pkg::PWR_W + sbpp_pkg::FRAME_W + 7) / 8) * 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sbpp_pkg::tok_ctl_t                      tail_ctl,
  input  logic [BANDS-1:0][sbpp_pkg::PWR_W-1:0]   res_pwr,
  input  logic [BANDS-1:0][BIN_W-1:0]             res_bin,
  input  logic [sbpp_pkg::PWR_W-1:0]              power_min,
  output logic                                    busy,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [DATA_W-1:0]                       out_tdata,
  output logic [BAND_W-1:0]                       out_tuser,
  output logic                                    out_tlast
);

  logic [BANDS-1:0]                        mask_r;
  logic [BANDS-1:0]                        mask_nxt;
  logic [BANDS-1:0][sbpp_pkg::PWR_W-1:0]   pwr_r;
  logic [BANDS-1:0][BIN_W-1:0]             bin_r;
  logic [sbpp_pkg::FRAME_W-1:0]            frame_r;
  logic [sbpp_pkg::FRAME_W-1:0]            frame_cnt_r;
  logic [BANDS-1:0]                        pass;
  logic [BANDS-1:0]                        sel_hot;
  logic [BANDS-1:0]                        rest;
  logic [BAND_W-1:0]                       sel_idx;
  logic                                    load;
  logic                                    sent;

  assign busy = |mask_r;
  // a new frame is taken only into an empty buffer
  assign load = tail_ctl.vld && tail_ctl.last && !busy;
  assign sent = out_tvalid && out_tready;

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      pass[b] = res_pwr[b] >= power_min;
    end
  end

  assign sel_hot = mask_r & (~mask_r + 1'b1);
  assign rest    = mask_r & ~sel_hot;

  always_comb begin
    sel_idx = '0;
    for (int b = BANDS - 1; b >= 0; b--) begin
      if (mask_r[b]) begin
        sel_idx = BAND_W'(b);
      end
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = pass;
    end else if (sent) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      frame_cnt_r <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (load) begin
        frame_cnt_r <= frame_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pwr_r   <= res_pwr;
      bin_r   <= res_bin;
      frame_r <= frame_cnt_r;
    end
  end

  assign out_tvalid = busy;
  assign out_tuser  = sel_idx;
  assign out_tlast  = ~|rest;
  assign out_tdata  = DATA_W'({frame_r, pwr_r[sel_idx], bin_r[sel_idx]});

endmodule
